/* hw/rtl/crc_lpt_pkg.sv */
// Shared types, constants and the CRC32C byte function of the keyed probe table.
package crc_lpt_pkg;

   localparam int HASH_W = 32;
   localparam int VALUE_W = 64;
   localparam logic [HASH_W-1:0] CRC_INIT = 32'hffff_ffff;
   localparam logic [HASH_W-1:0] CRC_POLY = 32'h82f6_3b78;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [7:0]         key_byte;
      logic               key_last;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] found_value;
      logic [3:0]         slot_index;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       mod_step;
      logic       probe_start;
      logic       probe_next;
      logic       rd_en;
      logic       wr_en;
      logic       clr_step;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_take_value;
   } dp_cmd_type;

   typedef struct packed {
      logic hash_zero;
      logic is_insert;
      logic mod_done;
      logic hit;
      logic probe_last;
      logic clr_done;
   } dp_stat_type;

   function automatic logic [HASH_W-1:0] crc_byte_f(input logic [HASH_W-1:0] crc,
                                                    input logic [7:0] data);
      logic [HASH_W-1:0] c;
      c = crc ^ {{(HASH_W-8){1'b0}}, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/crc32c_keyed_linear_probe_table.sv */
// Key-hashed table with linear probing: CRC32C of streamed key bytes, lookup and insert.
//
// Input channel: drive start with a key byte beat on req_data; the beat is taken at
// a rising edge where start is high and busy is low. Bytes that are not last leave
// busy low, so a key streams in at one byte per cycle.
// The last byte ends the key: its CRC32C is finished and the action (lookup or
// insert) runs against the table while busy is high.
// Result channel: rsp_valid pulses for one cycle with rsp_data; the receiver cannot
// stall it, so there is no backpressure and nothing to hold.
// The home slot is the hash modulo TABLE_SLOTS, found by a reciprocal-multiply
// remainder when TABLE_SLOTS is not a power of two. A zero hash is answered
// without a probe.
// Each probed slot costs one registered RAM read and one compare, and a probe
// walks up to TABLE_SLOTS slots.
// Reset clears the running CRC and then sweeps the hash RAM, one slot per cycle,
// with busy high; the value RAM is not cleared.
module crc32c_keyed_linear_probe_table
   import crc_lpt_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   crc_lpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .key_last (req_data.key_last),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   crc_lpt_dp #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_data(rsp_data)
   );

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_no_rsp_mid_key : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.key_last) |=> !rsp_valid)
      else $error("result after a byte that was not last");

   a_fail_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.slot_index == 4'd0 && rsp_data.found_value == '0))
      else $error("failed result carries slot or value");

   a_ok_nonzero_hash : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK) |-> (rsp_data.key_hash != '0))
      else $error("zero hash reported as stored or found");

endmodule

/* hw/rtl/crc_lpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module crc_lpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/crc_lpt_dp.sv */
// Datapath: CRC accumulation, home-slot modulo, slot probe, table RAMs and result register.
module crc_lpt_dp
   import crc_lpt_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [IDX_W:0] MOD_N = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [HASH_W-1:0] RECIP = HASH_W'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
   localparam logic [1:0] MOD_STEPS = 2'd2;

   logic [HASH_W-1:0]  crc_ff, crc_in;
   logic [HASH_W-1:0]  crc_next;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic               action_ff, action_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [HASH_W-1:0]  quo_ff, quo_in;
   logic [1:0]         mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   probe_cnt_ff, probe_cnt_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   rsp_type            rsp_ff, rsp_in;

   logic [2*HASH_W-1:0] recip_prod;
   logic [2*IDX_W+1:0]  qn_prod;
   logic [IDX_W:0]      rem_est;
   logic [IDX_W-1:0]   home;
   logic [IDX_W+3:0]   slot_ext;
   logic [HASH_W-1:0]  rd_hash;
   logic [VALUE_W-1:0] rd_value;
   logic               hash_wr_en;
   logic [IDX_W-1:0]   hash_wr_addr;
   logic [HASH_W-1:0]  hash_wr_data;

   assign crc_next   = crc_byte_f(crc_ff, req_data.key_byte);
   assign recip_prod = hash_ff * RECIP;
   assign qn_prod    = quo_ff[IDX_W:0] * MOD_N;
   assign rem_est    = hash_ff[IDX_W:0] - qn_prod[IDX_W:0];
   assign home       = IS_POW2 ? hash_ff[IDX_W-1:0] : rem_ff;
   assign slot_ext   = (IDX_W + 4)'(slot_ff);

   always_comb begin
      crc_in       = crc_ff;
      hash_in      = hash_ff;
      action_in    = action_ff;
      value_in     = value_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mod_cnt_in   = mod_cnt_ff;
      slot_in      = slot_ff;
      probe_cnt_in = probe_cnt_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         if (req_data.key_last) begin
            crc_in     = CRC_INIT;
            hash_in    = ~crc_next;
            action_in  = req_data.action;
            value_in   = req_data.value;
            rem_in     = '0;
            mod_cnt_in = '0;
         end else begin
            crc_in = crc_next;
         end
      end

      // estimate the quotient by reciprocal multiply, then fix up with one subtract
      if (cmd.mod_step) begin
         if (mod_cnt_ff == '0) begin
            quo_in = recip_prod[2*HASH_W-1:HASH_W];
         end else begin
            rem_in = (rem_est >= MOD_N) ? IDX_W'(rem_est - MOD_N) : rem_est[IDX_W-1:0];
         end
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end

      if (cmd.probe_start) begin
         slot_in      = home;
         probe_cnt_in = '0;
      end else if (cmd.probe_next) begin
         slot_in      = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         probe_cnt_in = probe_cnt_ff + 1'b1;
      end

      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_in.status      = cmd.rsp_status;
         rsp_in.key_hash    = hash_ff;
         rsp_in.found_value = cmd.rsp_take_value ? rd_value : '0;
         rsp_in.slot_index  = (cmd.rsp_status == ST_OK) ? slot_ext[3:0] : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         clr_addr_ff <= '0;
      end else begin
         crc_ff      <= crc_in;
         clr_addr_ff <= clr_addr_in;
      end
      hash_ff      <= hash_in;
      action_ff    <= action_in;
      value_ff     <= value_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      mod_cnt_ff   <= mod_cnt_in;
      slot_ff      <= slot_in;
      probe_cnt_ff <= probe_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign hash_wr_en   = cmd.wr_en || cmd.clr_step;
   assign hash_wr_addr = cmd.clr_step ? clr_addr_ff : slot_ff;
   assign hash_wr_data = cmd.clr_step ? '0 : hash_ff;

   crc_lpt_ram #(
      .WIDTH(HASH_W),
      .DEPTH(TABLE_SLOTS)
   ) u_hash_ram (
      .clock  (clock),
      .wr_en  (hash_wr_en),
      .wr_addr(hash_wr_addr),
      .wr_data(hash_wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(slot_ff),
      .rd_data(rd_hash)
   );

   crc_lpt_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(TABLE_SLOTS)
   ) u_value_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(slot_ff),
      .wr_data(value_ff),
      .rd_en  (cmd.rd_en),
      .rd_addr(slot_ff),
      .rd_data(rd_value)
   );

   always_comb begin
      stat.hash_zero  = (hash_ff == '0);
      stat.is_insert  = (action_ff == ACT_INSERT);
      stat.mod_done   = IS_POW2 || (mod_cnt_ff == MOD_STEPS);
      stat.hit        = (rd_hash == hash_ff) || ((action_ff == ACT_INSERT) && (rd_hash == '0));
      stat.probe_last = (probe_cnt_ff == LAST_SLOT);
      stat.clr_done   = (clr_addr_ff == LAST_SLOT);
   end

   assign rsp_data = rsp_ff;

endmodule

/* hw/rtl/crc_lpt_ctrl.sv */
// Controller: sequences table clear, byte beats, modulo, slot probe and result strobe.
module crc_lpt_ctrl
   import crc_lpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        key_last,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_READ,
      S_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_status = ST_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (key_last) begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (stat.hash_zero) begin
               // zero hash is the free mark: never stored, never found
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = stat.is_insert ? ST_FULL : ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else if (stat.mod_done) begin
               cmd.probe_start = 1'b1;
               state_in        = S_READ;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (stat.hit) begin
               cmd.rsp_load       = 1'b1;
               cmd.rsp_status     = ST_OK;
               cmd.rsp_take_value = !stat.is_insert;
               cmd.wr_en          = stat.is_insert;
               state_in           = S_IDLE;
            end else if (stat.probe_last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = stat.is_insert ? ST_FULL : ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sim/crc_lpt_table_monitor.sv */
// Channel monitor for the keyed probe table: predicts each answer and compares it.
module crc_lpt_table_monitor
   import crc_lpt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   logic [HASH_W-1:0]  key_crc;
   logic [HASH_W-1:0]  slot_hash [SLOTS];
   logic [VALUE_W-1:0] slot_value [SLOTS];
   rsp_type            pending_answers [$];
   int                 bad = 0;

   function automatic logic [HASH_W-1:0] fold_key_byte(input logic [HASH_W-1:0] crc,
                                                        input logic [7:0] d);
      logic [HASH_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Fold one key beat; on the last byte run the probe against the table copy.
   task automatic resolve_key_beat(input req_type b);
      rsp_type           ans;
      logic [HASH_W-1:0] h;
      int                s;
      key_crc = fold_key_byte(key_crc, b.key_byte);
      if (!b.key_last) begin
         return;
      end
      h = ~key_crc;
      key_crc = CRC_INIT;
      ans = '0;
      ans.key_hash = h;
      ans.status = (b.action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
      if (h != '0) begin
         for (int n = 0; n < SLOTS && ans.status != ST_OK; n++) begin
            s = (int'(h % SLOTS) + n) % SLOTS;
            if (b.action == ACT_LOOKUP) begin
               if (slot_hash[s] == h) begin
                  ans.status = ST_OK;
                  ans.found_value = slot_value[s];
                  ans.slot_index = 4'(s);
               end
            end else if (slot_hash[s] == '0 || slot_hash[s] == h) begin
               slot_hash[s] = h;
               slot_value[s] = b.value;
               ans.status = ST_OK;
               ans.slot_index = 4'(s);
            end
         end
      end
      pending_answers.push_back(ans);
   endtask

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         key_crc = CRC_INIT;
         for (int i = 0; i < SLOTS; i++) begin
            slot_hash[i] = '0;
            slot_value[i] = '0;
         end
         pending_answers.delete();
      end else begin
         if (start && !busy) begin
            resolve_key_beat(req_data);
         end
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               bad++;
               if (bad <= 10) begin
                  $display("%0t: result beat with none expected: status %0d hash %h",
                           $time, rsp_data.status, rsp_data.key_hash);
               end
            end else begin
               wanted = pending_answers.pop_front();
               if (rsp_data.status !== wanted.status ||
                   rsp_data.key_hash !== wanted.key_hash ||
                   rsp_data.found_value !== wanted.found_value ||
                   rsp_data.slot_index !== wanted.slot_index) begin
                  bad++;
                  if (bad <= 10) begin
                     $display("%0t: exp status %0d hash %h value %h slot %0d", $time,
                              wanted.status, wanted.key_hash, wanted.found_value,
                              wanted.slot_index);
                     $display("%0t: got status %0d hash %h value %h slot %0d", $time,
                              rsp_data.status, rsp_data.key_hash, rsp_data.found_value,
                              rsp_data.slot_index);
                  end
               end
            end
         end
      end
      mismatches <= bad;
      outstanding <= pending_answers.size();
   end

endmodule

/* sim/tb_crc32c_keyed_linear_probe_table.sv */
// Testbench top for the keyed probe table: key stimulus, watchdog and verdict.
module tb_crc32c_keyed_linear_probe_table;
   import crc_lpt_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BEATS = 400;
   localparam int POOL_SIZE = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;
   int      beats = 0;
   int      stall_cycles = 0;
   bit      quiet = 1'b0;

   logic [HASH_W-1:0] hash_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   crc32c_keyed_linear_probe_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   crc_lpt_table_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      return {$urandom(), $urandom()};
   endfunction

   // Four key bytes, low byte first, whose finished CRC32C equals hash:
   // unwind the 32 register shifts back from the target state.
   function automatic logic [31:0] forge_key(input logic [HASH_W-1:0] hash);
      logic [HASH_W-1:0] c;
      c = ~hash;
      for (int i = 0; i < 32; i++) begin
         if (c[31]) begin
            c = ((c ^ CRC_POLY) << 1) | 32'd1;
         end else begin
            c = c << 1;
         end
      end
      return c ^ CRC_INIT;
   endfunction

   task automatic send_beat(input req_type b);
      if (!quiet && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      beats++;
   endtask

   // Stream a key of len bytes from kb, low byte first; action and value count
   // only on the last beat, so randomize them elsewhere.
   task automatic send_key(input logic act, input logic [47:0] kb, input int len,
                           input logic [VALUE_W-1:0] val);
      req_type b;
      for (int i = 0; i < len; i++) begin
         b.key_last = (i == len - 1);
         b.action = b.key_last ? act : 1'($urandom_range(1));
         b.key_byte = kb[8*i +: 8];
         b.value = b.key_last ? val : rand_value();
         send_beat(b);
      end
   endtask

   task automatic send_hashed_key(input logic act, input logic [HASH_W-1:0] hash,
                                  input logic [VALUE_W-1:0] val);
      send_key(act, {16'h0, forge_key(hash)}, 4, val);
   endtask

   initial begin
      logic [HASH_W-1:0] h;
      logic [47:0]       kb;
      logic              act;
      int                len;
      int                pick;
      int                stop_at;
      // Cluster homes at the last and first slots so probes wrap around.
      for (int i = 0; i < POOL_SIZE; i++) begin
         h = $urandom();
         if (h[31:4] == '0) begin
            h[31] = 1'b1;
         end
         case (i % 4)
            0: h[3:0] = 4'd15;
            1: h[3:0] = 4'd0;
            default: ;
         endcase
         hash_pool[i] = h;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_key(ACT_LOOKUP, 48'hff, 1, rand_value());
      send_hashed_key(ACT_LOOKUP, '0, rand_value());
      send_hashed_key(ACT_INSERT, '0, '1);
      send_key(ACT_INSERT, 48'h01, 1, '1);
      send_hashed_key(ACT_INSERT, hash_pool[0], '1);
      send_hashed_key(ACT_INSERT, hash_pool[4], '0);
      send_hashed_key(ACT_LOOKUP, hash_pool[4], rand_value());
      send_key(ACT_INSERT, 48'h8000, 2, rand_value());

      stop_at = beats + RANDOM_BEATS;
      while (beats < stop_at) begin
         quiet = (beats >= 150 && beats < 270);
         pick = $urandom_range(99);
         act = ($urandom_range(99) < 35) ? ACT_INSERT : ACT_LOOKUP;
         if (pick < 8) begin
            send_hashed_key(act, '0, rand_value());
         end else if (pick < 75) begin
            send_hashed_key(act, hash_pool[$urandom_range(POOL_SIZE - 1)], rand_value());
         end else begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < 6; i++) begin
               kb[8*i +: 8] = 8'($urandom_range(255, 1));
            end
            send_key(act, kb, len, rand_value());
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/crc_lpt_pkg.sv
hw/rtl/crc_lpt_ram.sv
hw/rtl/crc_lpt_dp.sv
hw/rtl/crc_lpt_ctrl.sv
hw/rtl/crc32c_keyed_linear_probe_table.sv
sim/crc_lpt_table_monitor.sv
sim/tb_crc32c_keyed_linear_probe_table.sv
